// ----- rtl/core/lir_pkg.sv -----
// Shared types and constants for the linear interpolation resampler.
// Used by every module and interface of the block but lir_chk; depends on nothing.
`default_nettype none
package lir_pkg;

	localparam int MAX_CHANNELS_DEF = 4;
	localparam int MAX_UPSAMPLE_DEF = 8;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam int RATE_W     = 19;
	localparam int CH_CFG_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int RESULT_CAP = 64;
	localparam int CNT_W      = 32;
	localparam int DIV_W      = 64;
	localparam int DVS_W      = RATE_W + 1;
	localparam int PROD_W     = CNT_W + RATE_W;

	localparam logic [RATE_W-1:0]   SOURCE_RESET   = RATE_W'(48000);
	localparam logic [RATE_W-1:0]   TARGET_RESET   = RATE_W'(16000);
	localparam logic [CH_CFG_W-1:0] CHANNELS_RESET = CH_CFG_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE   = 2'd0,
		CFG_TARGET   = 2'd1,
		CFG_CHANNELS = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DIV_FIX,
		OP_FIX_LOAD,
		OP_MUL_LIM,
		OP_DIV_LIM,
		OP_LIM_LOAD,
		OP_DROP_HELD,
		OP_MUL_A,
		OP_MUL_B,
		OP_DIV_BLEND,
		OP_BLEND_LOAD,
		OP_DIV_ADV,
		OP_ADV_LOAD,
		OP_HOLD,
		OP_PUT,
		OP_FLUSH
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIX,
		S_FIX_W,
		S_LIM,
		S_LIM_D,
		S_LIM_W,
		S_HELD,
		S_HELD_PUT,
		S_LOOP,
		S_MUL_A,
		S_MUL_B,
		S_BLEND_D,
		S_BLEND_W,
		S_ADV,
		S_ADV_W,
		S_DECIDE
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   src_held;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_close;
		logic end_q;
		logic r_ge_t;
		logic held_v;
		logic od_lt_lim;
		logic left_lt;
		logic room;
		logic last_ch;
		logic div_done;
		logic put_ok;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/lir_in_if.sv -----
// Input channel of the resampler: one PCM sample word with its clip end flag.
// Depends on lir_pkg for the default sample width.
`default_nettype none
interface lir_in_if import lir_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          clip_end;

	modport source(output valid, sample_in, clip_end, input ready);
	modport sink(input valid, sample_in, clip_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lir_out_if.sv -----
// Output channel of the resampler: one interpolated sample word with its tags.
// Depends on lir_pkg for the default sample width.
`default_nettype none
interface lir_out_if import lir_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [1:0]                    lane;
	logic                          burst_last;
	logic                          clip_done;

	modport source(output valid, sample_out, lane, burst_last, clip_done, input ready);
	modport sink(input valid, sample_out, lane, burst_last, clip_done, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/linear_interp_resampler.sv -----
// Linear interpolation sample rate converter, top level.
// Input channel in_ch takes one interleaved PCM word per handshake, with
// clip_end on the final word of a clip. Output channel out_ch gives one
// interpolated word per handshake, tagged with its lane, burst_last on the
// final word caused by an input word, and clip_done on the clip's last word.
// Rates and channel count are written through cfg_we/cfg_idx/cfg_data while
// the block is idle; the user must keep to this, as the block leaves it
// unchecked. A word that does not complete a frame leaves the block ready
// for the next. A completed frame holds off input while the shared serial
// divider, one quotient bit per cycle over 64 bits, runs a phase reduction
// when the phase must be reduced, the count limit, then per output frame a
// blend per channel and an advance, with a put per word.
// Reset clears the frames, counters and phase and loads 48000 Hz to
// 16000 Hz mono. A stalled receiver holds the output register; one more
// word waits in a staging register and the sequencer pauses behind it.
`default_nettype none
module linear_interp_resampler import lir_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	lir_in_if.sink                    in_ch,
	lir_out_if.source                 out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [RATE_W-1:0]    cfg_data
);
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ready;

	assign in_ch.ready = ready;

	lir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lir_dp #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_UPSAMPLE (MAX_UPSAMPLE),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_sample  (in_ch.sample_in),
		.in_end     (in_ch.clip_end),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_sample (out_ch.sample_out),
		.out_lane   (out_ch.lane),
		.out_last   (out_ch.burst_last),
		.out_done   (out_ch.clip_done),
		.cmd        (cmd),
		.stat       (stat)
	);
endmodule
`default_nettype wire

// ----- rtl/core/lir_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on lir_pkg for the operand widths.
`default_nettype none
module lir_div import lir_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quot,
	output logic [DVS_W-1:0]      rem
);
	localparam int IT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [IT_W-1:0]  it_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= !start && busy_q && (it_q == IT_W'(DIV_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + IT_W'(1);
				if (it_q == IT_W'(DIV_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ----- rtl/core/lir_dp.sv -----
// Datapath: configuration, frame store, phase and count registers, blend
// arithmetic, result staging and output register. Uses lir_pkg and lir_div.
`default_nettype none
module lir_dp import lir_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_idx,
	input  wire logic [RATE_W-1:0]             cfg_data,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	input  wire logic                          in_end,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic [1:0]                         out_lane,
	output logic                               out_last,
	output logic                               out_done,
	input  wire dp_cmd_t                       cmd,
	output dp_stat_t                           stat
);
	localparam int LW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NW = SAMPLE_BITS + RATE_W + 2;
	localparam int UPW = $clog2(MAX_UPSAMPLE + 1);
	localparam int T8W = RATE_W + UPW;

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;

	logic [RATE_W-1:0]   src_q, tgt_q;
	logic [CH_CFG_W-1:0] chn_q;
	logic [RATE_W-1:0]   s_eff, t_eff, tgt1;
	logic [T8W-1:0]      t8;
	logic [3:0]          chans;

	smp_t prev_q [MAX_CHANNELS];
	smp_t cur_q  [MAX_CHANNELS];
	smp_t held_q [MAX_CHANNELS];
	smp_t vals_q [MAX_CHANNELS];

	logic [LW-1:0]     lane_q, ch_q, lane;
	logic [3:0]        lane_nx;
	logic [CNT_W-1:0]  frames_q, od_q, left_q;
	logic [RATE_W-1:0] r_q;
	logic [DIV_W-1:0]  lim_q;
	logic [PROD_W-1:0] prod_q;
	logic              held_v_q, end_q, neg_q;
	logic [6:0]        n_q;
	logic signed [NW-1:0] p1_s1, p2_s1, num;
	logic [NW-1:0]     mag;

	logic              stage_v_q, stage_done_q;
	smp_t              stage_smp_q;
	logic [LW-1:0]     stage_ch_q;
	logic              out_v_q;

	logic              div_start, div_done;
	logic [DIV_W-1:0]  div_a, quot;
	logic [DVS_W-1:0]  div_b, rem;
	logic              last_ch, done_flag, out_free, push;
	smp_t              a_sel, b_sel, put_val, blend_val;

	// Effective rates and channel count after saturation.
	always_comb begin
		s_eff = (src_q == '0) ? RATE_W'(1) : src_q;
		tgt1  = (tgt_q == '0) ? RATE_W'(1) : tgt_q;
		t8    = T8W'(s_eff) * T8W'(MAX_UPSAMPLE);
		t_eff = (T8W'(tgt1) > t8) ? RATE_W'(t8) : tgt1;
		if (chn_q == '0)
			chans = 4'd1;
		else if (4'(chn_q) > 4'(MAX_CHANNELS))
			chans = 4'(MAX_CHANNELS);
		else
			chans = 4'(chn_q);
	end

	assign lane    = (4'(lane_q) >= chans) ? '0 : lane_q;
	assign lane_nx = 4'(lane) + 4'd1;
	assign last_ch = (4'(ch_q) + 4'd1) == chans;
	assign out_free = !out_v_q || out_ready;
	assign done_flag = end_q && ((DIV_W'(od_q) + DIV_W'(1)) == lim_q);

	// The left neighbour falls back to the last frame once the clip has run out.
	assign a_sel = ((left_q + CNT_W'(1)) < frames_q) ? prev_q[ch_q] : cur_q[ch_q];
	assign b_sel = cur_q[ch_q];
	assign num   = p1_s1 + p2_s1;
	assign mag   = num[NW-1] ? NW'(-num) : NW'(num);
	assign blend_val = neg_q ? SAMPLE_BITS'(-quot) : SAMPLE_BITS'(quot);
	assign put_val   = cmd.src_held ? held_q[ch_q] : vals_q[ch_q];

	always_comb begin
		div_start = 1'b1;
		div_a     = '0;
		div_b     = DVS_W'(t_eff);
		case (cmd.op)
			OP_DIV_FIX: div_a = DIV_W'(r_q);
			OP_DIV_LIM: begin
				div_a = DIV_W'({prod_q, 1'b0}) + DIV_W'(s_eff);
				div_b = {s_eff, 1'b0};
			end
			OP_DIV_BLEND: begin
				div_a = DIV_W'({mag, 1'b0}) + DIV_W'(t_eff);
				div_b = {t_eff, 1'b0};
			end
			OP_DIV_ADV: div_a = DIV_W'(r_q) + DIV_W'(s_eff);
			default: div_start = 1'b0;
		endcase
	end

	lir_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign push = (cmd.op == OP_PUT || cmd.op == OP_FLUSH) && stage_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q     <= SOURCE_RESET;
			tgt_q     <= TARGET_RESET;
			chn_q     <= CHANNELS_RESET;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_q[i] <= '0;
				cur_q[i]  <= '0;
				held_q[i] <= '0;
			end
			lane_q    <= '0;
			ch_q      <= '0;
			frames_q  <= '0;
			od_q      <= '0;
			left_q    <= '0;
			r_q       <= '0;
			held_v_q  <= 1'b0;
			end_q     <= 1'b0;
			n_q       <= '0;
			stage_v_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SOURCE:   src_q <= cfg_data;
					CFG_TARGET:   tgt_q <= cfg_data;
					CFG_CHANNELS: chn_q <= CH_CFG_W'(cfg_data);
					default: ;
				endcase
			end
			if (push)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
			case (cmd.op)
				OP_ACCEPT: begin
					for (int i = 0; i < MAX_CHANNELS; i++) begin
						if (lane == '0)
							prev_q[i] <= cur_q[i];
						if (LW'(i) == lane)
							cur_q[i] <= in_sample;
						else if (lane == '0)
							cur_q[i] <= '0;
					end
					end_q <= in_end;
					n_q   <= '0;
					ch_q  <= '0;
					if (lane_nx >= chans || in_end) begin
						lane_q   <= '0;
						frames_q <= frames_q + CNT_W'(1);
					end else begin
						lane_q <= LW'(lane_nx);
					end
				end
				OP_FIX_LOAD: r_q <= RATE_W'(rem);
				OP_DROP_HELD: held_v_q <= 1'b0;
				OP_BLEND_LOAD: ch_q <= last_ch ? '0 : ch_q + LW'(1);
				OP_ADV_LOAD: begin
					left_q <= left_q + CNT_W'(quot);
					r_q    <= RATE_W'(rem);
				end
				OP_HOLD: begin
					for (int i = 0; i < MAX_CHANNELS; i++)
						held_q[i] <= vals_q[i];
					held_v_q <= 1'b1;
				end
				OP_PUT: begin
					stage_v_q <= 1'b1;
					n_q       <= n_q + 7'd1;
					if (last_ch) begin
						ch_q <= '0;
						od_q <= od_q + CNT_W'(1);
						if (cmd.src_held)
							held_v_q <= 1'b0;
					end else begin
						ch_q <= ch_q + LW'(1);
					end
				end
				OP_FLUSH: begin
					stage_v_q <= 1'b0;
					if (end_q) begin
						for (int i = 0; i < MAX_CHANNELS; i++) begin
							prev_q[i] <= '0;
							cur_q[i]  <= '0;
							held_q[i] <= '0;
						end
						held_v_q <= 1'b0;
						frames_q <= '0;
						od_q     <= '0;
						left_q   <= '0;
						r_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_MUL_LIM: prod_q <= PROD_W'(frames_q) * PROD_W'(t_eff);
			OP_LIM_LOAD: lim_q <= quot;
			OP_MUL_A: p1_s1 <= NW'(a_sel * $signed({1'b0, RATE_W'(t_eff - r_q)}));
			OP_MUL_B: p2_s1 <= NW'(b_sel * $signed({1'b0, r_q}));
			OP_DIV_BLEND: neg_q <= num[NW-1];
			OP_BLEND_LOAD: vals_q[ch_q] <= blend_val;
			OP_PUT: begin
				stage_smp_q  <= put_val;
				stage_ch_q   <= ch_q;
				stage_done_q <= done_flag;
			end
			default: ;
		endcase
		if (push) begin
			out_sample <= stage_smp_q;
			out_lane   <= 2'(stage_ch_q);
			out_done   <= stage_done_q;
			out_last   <= (cmd.op == OP_FLUSH);
		end
	end

	assign out_valid = out_v_q;

	always_comb begin
		stat.frame_close = (lane_nx >= chans) || in_end;
		stat.end_q       = end_q;
		stat.r_ge_t      = r_q >= t_eff;
		stat.held_v      = held_v_q;
		stat.od_lt_lim   = DIV_W'(od_q) < lim_q;
		stat.left_lt     = (left_q + CNT_W'(1)) < frames_q;
		stat.room        = (8'(n_q) + 8'(chans)) <= 8'(RESULT_CAP);
		stat.last_ch     = last_ch;
		stat.div_done    = div_done;
		stat.put_ok      = !stage_v_q || out_free;
		stat.out_free    = out_free;
	end
endmodule
`default_nettype wire

// ----- rtl/core/lir_ctrl.sv -----
// Controller: sequences one input word through frame update, phase reduction,
// count limit, held output release and the interpolation loop. Depends on lir_pkg.
`default_nettype none
module lir_ctrl import lir_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);
	ctrl_state_t state_q, state_nx;
	logic        go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	// At clip end the loop runs to the final count; else to a hold or the last frame.
	assign go = stat.room && (stat.end_q ? stat.od_lt_lim : (!stat.held_v && stat.left_lt));

	always_comb begin
		state_nx     = state_q;
		cmd.op       = OP_NONE;
		cmd.src_held = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_ACCEPT;
					if (stat.frame_close)
						state_nx = S_FIX;
				end
			end
			S_FIX: begin
				if (stat.r_ge_t) begin
					cmd.op   = OP_DIV_FIX;
					state_nx = S_FIX_W;
				end else begin
					state_nx = S_LIM;
				end
			end
			S_FIX_W: if (stat.div_done) begin
				cmd.op   = OP_FIX_LOAD;
				state_nx = S_LIM;
			end
			S_LIM: begin
				cmd.op   = OP_MUL_LIM;
				state_nx = S_LIM_D;
			end
			S_LIM_D: begin
				cmd.op   = OP_DIV_LIM;
				state_nx = S_LIM_W;
			end
			S_LIM_W: if (stat.div_done) begin
				cmd.op   = OP_LIM_LOAD;
				state_nx = S_HELD;
			end
			S_HELD: begin
				if (stat.held_v && stat.od_lt_lim) begin
					state_nx = S_HELD_PUT;
				end else begin
					if (stat.held_v && stat.end_q)
						cmd.op = OP_DROP_HELD;
					state_nx = S_LOOP;
				end
			end
			S_HELD_PUT: if (stat.put_ok) begin
				cmd.op       = OP_PUT;
				cmd.src_held = 1'b1;
				if (stat.last_ch)
					state_nx = S_LOOP;
			end
			S_LOOP: begin
				if (go) begin
					state_nx = S_MUL_A;
				end else if (stat.out_free) begin
					cmd.op   = OP_FLUSH;
					state_nx = S_IDLE;
				end
			end
			S_MUL_A: begin
				cmd.op   = OP_MUL_A;
				state_nx = S_MUL_B;
			end
			S_MUL_B: begin
				cmd.op   = OP_MUL_B;
				state_nx = S_BLEND_D;
			end
			S_BLEND_D: begin
				cmd.op   = OP_DIV_BLEND;
				state_nx = S_BLEND_W;
			end
			S_BLEND_W: if (stat.div_done) begin
				cmd.op   = OP_BLEND_LOAD;
				state_nx = stat.last_ch ? S_ADV : S_MUL_A;
			end
			S_ADV: begin
				cmd.op   = OP_DIV_ADV;
				state_nx = S_ADV_W;
			end
			S_ADV_W: if (stat.div_done) begin
				cmd.op   = OP_ADV_LOAD;
				state_nx = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.od_lt_lim) begin
					state_nx = S_HELD_PUT;
				end else begin
					cmd.op   = OP_HOLD;
					state_nx = S_LOOP;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		// The released-value path shares the put state; only a held frame reads held data.
		if (state_q == S_HELD_PUT && !stat.held_v)
			cmd.src_held = 1'b0;
	end
endmodule
`default_nettype wire

// ----- rtl/core/lir_chk.sv -----
// Port-level checks for the resampler, bound to the top level.
// Depends on linear_interp_resampler's ports only.
`default_nettype none
module lir_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic in_end,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_last,
	input wire logic out_done
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_tags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_last) && $stable(out_done))
		else $error("output word tags changed while stalled");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_end |=> !in_ready)
		else $error("input taken right after a clip end word");
endmodule

bind linear_interp_resampler lir_chk u_lir_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_end    (in_ch.clip_end),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_last  (out_ch.burst_last),
	.out_done  (out_ch.clip_done)
);
`default_nettype wire
